// ===== hw/rtl/fraction_reducer_defines.svh =====
// Assertion macros used by the fraction reducer controller.
`ifndef FRACTION_REDUCER_DEFINES_SVH
`define FRACTION_REDUCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/frd_pkg.sv =====
// Types, constants and status codes for the fraction reducer.
package frd_pkg;

    localparam int DATA_W = 32;
    localparam int MAG_W  = DATA_W - 1;
    localparam int SH_W   = $clog2(MAG_W);

    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STS_MOST_NEG = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] numer_in;
        logic signed [DATA_W-1:0] denom_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] numer_out;
        logic [MAG_W-1:0]         denom_out;
        logic [1:0]               status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic trivial;
        logic gcd_done;
        logic div_last;
    } sts_t;

endpackage

// ===== hw/rtl/frd_datapath.sv =====
// Datapath: magnitude split, binary GCD, two-lane restoring divider, output register.
module frd_datapath
    import frd_pkg::*;
(
    input  logic clk,
    input  req_t req_data,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp_data
);

    logic [DATA_W-1:0] n_raw;
    logic [DATA_W-1:0] d_raw;
    logic [DATA_W-1:0] n_neg;
    logic [DATA_W-1:0] d_neg;
    logic [MAG_W-1:0]  n_mag;
    logic [MAG_W-1:0]  d_mag;
    logic [1:0]        load_status;
    logic              load_trivial;

    logic [MAG_W-1:0] a_reg, a_next;
    logic [MAG_W-1:0] b_reg, b_next;
    logic [SH_W-1:0]  k_reg, k_next;
    logic [MAG_W-1:0] g_reg, g_next;
    logic [MAG_W-1:0] qn_reg, qn_next;
    logic [MAG_W-1:0] qd_reg, qd_next;
    logic [MAG_W-1:0] rn_reg, rn_next;
    logic [MAG_W-1:0] rd_reg, rd_next;
    logic [SH_W-1:0]  cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             triv_reg, triv_next;
    logic [1:0]       status_reg, status_next;
    rsp_t             rsp_reg, rsp_next;

    logic [MAG_W:0]   rn_sh;
    logic [MAG_W:0]   rd_sh;
    logic [MAG_W:0]   g_ext;
    logic             rn_ge;
    logic             rd_ge;
    logic [DATA_W-1:0] qn_ext;
    logic [DATA_W-1:0] numer_val;

    always_comb
    begin
        n_raw = req_data.numer_in;
        d_raw = req_data.denom_in;
        n_neg = ~n_raw + 1'b1;
        d_neg = ~d_raw + 1'b1;
        n_mag = n_raw[DATA_W-1] ? n_neg[MAG_W-1:0] : n_raw[MAG_W-1:0];
        d_mag = d_raw[DATA_W-1] ? d_neg[MAG_W-1:0] : d_raw[MAG_W-1:0];

        // Zero denominator is checked before the most negative value.
        if (d_raw == '0)
        begin
            load_status = STS_ZERO_DEN;
        end
        else if (n_raw == MOST_NEG || d_raw == MOST_NEG)
        begin
            load_status = STS_MOST_NEG;
        end
        else
        begin
            load_status = STS_OK;
        end
        load_trivial = (load_status != STS_OK) || (n_raw == '0);
    end

    always_comb
    begin
        g_ext = {1'b0, g_reg};
        rn_sh = {rn_reg, qn_reg[MAG_W-1]};
        rd_sh = {rd_reg, qd_reg[MAG_W-1]};
        rn_ge = rn_sh >= g_ext;
        rd_ge = rd_sh >= g_ext;

        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        g_next      = g_reg;
        qn_next     = qn_reg;
        qd_next     = qd_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        triv_next   = triv_reg;
        status_next = status_reg;

        if (cmd.load)
        begin
            a_next      = n_mag;
            b_next      = d_mag;
            qn_next     = n_mag;
            qd_next     = d_mag;
            k_next      = '0;
            neg_next    = n_raw[DATA_W-1] ^ d_raw[DATA_W-1];
            triv_next   = load_trivial;
            status_next = load_status;
        end

        // Binary GCD: strip common twos, halve a lone even one, subtract odd from odd.
        if (cmd.gcd_step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg > b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end

        if (cmd.div_init)
        begin
            g_next   = a_reg << k_reg;
            rn_next  = '0;
            rd_next  = '0;
            cnt_next = '0;
        end

        // Both magnitudes are divided by the same divisor, one quotient bit per cycle.
        if (cmd.div_step)
        begin
            rn_next  = rn_ge ? MAG_W'(rn_sh - g_ext) : rn_sh[MAG_W-1:0];
            rd_next  = rd_ge ? MAG_W'(rd_sh - g_ext) : rd_sh[MAG_W-1:0];
            qn_next  = {qn_reg[MAG_W-2:0], rn_ge};
            qd_next  = {qd_reg[MAG_W-2:0], rd_ge};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        qn_ext    = {1'b0, qn_reg};
        numer_val = neg_reg ? (~qn_ext + 1'b1) : qn_ext;
        rsp_next  = rsp_reg;
        if (cmd.out_load)
        begin
            rsp_next.status = status_reg;
            if (triv_reg)
            begin
                rsp_next.numer_out = '0;
                rsp_next.denom_out = MAG_W'(1);
            end
            else
            begin
                rsp_next.numer_out = numer_val;
                rsp_next.denom_out = qd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        g_reg      <= g_next;
        qn_reg     <= qn_next;
        qd_reg     <= qd_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        triv_reg   <= triv_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign sts.trivial  = load_trivial;
    assign sts.gcd_done = (a_reg == b_reg);
    assign sts.div_last = (cnt_reg == SH_W'(MAG_W - 1));
    assign rsp_data     = rsp_reg;

endmodule

// ===== hw/rtl/frd_ctrl.sv =====
// Controller: sequences load, GCD, division and output transfer for one item.
`include "fraction_reducer_defines.svh"

module frd_ctrl
    import frd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.trivial ? ST_FIN : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_GCD:
            begin
                cmd.gcd_step = !sts.gcd_done;
                cmd.div_init = sts.gcd_done;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // The result register holds until its transfer; a new result may replace it that same cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `FRD_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_reg != ST_IDLE, "load did not leave idle")
    `FRD_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
    `FRD_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_reg || !rsp_stall, "result overwritten")
    `FRD_ASSERT_NEXT(a_div_to_fin, cmd.div_step && sts.div_last, state_reg == ST_FIN, "late finish")
    `FRD_ASSERT_NEXT(a_out_after_load, cmd.out_load, out_valid_reg, "loaded result not offered")

endmodule

// ===== hw/rtl/fraction_reducer.sv =====
// Zero, zero-denominator and most-negative inputs skip the GCD loop and the divider;
// other items pass through the binary GCD loop (one step per cycle), a divisor setup step
// and the 31-step restoring divider before the result is loaded into the output register.
// A new item is taken only once the previous result is in the output register.
// Reset (rst_n, asynchronous, active low) clears the controller and the output valid flag.
module fraction_reducer
    import frd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t cmd;
    sts_t sts;

    frd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    frd_datapath u_datapath (
        .clk      (clk),
        .req_data (req_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

endmodule
